FILE: rtl/act_pkg.sv
`timescale 1ns / 1ps
package act_pkg;

  localparam int unsigned CodeCount = 23;

  typedef struct packed {
    logic [3:0] base;
    logic       first_base;
    logic [1:0] skip_bases;
    logic       reverse_strand;
    logic       use_db_table;
    logic       last_base;
  } act_in_t;

  typedef struct packed {
    logic [4:0] amino_acid;
    logic       end_of_protein;
    logic       no_residue;
  } act_out_t;

  typedef enum logic [0:0] {
    RegQueryCode = 1'b0,
    RegDbCode    = 1'b1
  } act_reg_e;

  // Residue indexes in "-ABCDEFGHIKLMNPQRSTVWXYZU*OJ"
  localparam logic [4:0] AaNone = 5'd0;
  localparam logic [4:0] AaB    = 5'd2;
  localparam logic [4:0] AaD    = 5'd4;
  localparam logic [4:0] AaE    = 5'd5;
  localparam logic [4:0] AaN    = 5'd13;
  localparam logic [4:0] AaQ    = 5'd15;
  localparam logic [4:0] AaX    = 5'd21;
  localparam logic [4:0] AaZ    = 5'd23;

  // Residue sets that merge into B and into Z
  localparam logic [27:0] AaSetBdn = (28'd1 << AaB) | (28'd1 << AaD) | (28'd1 << AaN);
  localparam logic [27:0] AaSetZeq = (28'd1 << AaZ) | (28'd1 << AaE) | (28'd1 << AaQ);

  function automatic logic [4:0] aa_of_char(input logic [7:0] c);
    logic [4:0] r;
    r = AaX;
    case (c)
      "A": r = 5'd1;  "B": r = 5'd2;  "C": r = 5'd3;  "D": r = 5'd4;
      "E": r = 5'd5;  "F": r = 5'd6;  "G": r = 5'd7;  "H": r = 5'd8;
      "I": r = 5'd9;  "K": r = 5'd10; "L": r = 5'd11; "M": r = 5'd12;
      "N": r = 5'd13; "P": r = 5'd14; "Q": r = 5'd15; "R": r = 5'd16;
      "S": r = 5'd17; "T": r = 5'd18; "V": r = 5'd19; "W": r = 5'd20;
      "X": r = 5'd21; "Y": r = 5'd22; "Z": r = 5'd23; "U": r = 5'd24;
      "*": r = 5'd25; "O": r = 5'd26; "J": r = 5'd27;
      default: r = AaX;
    endcase
    return r;
  endfunction

  function automatic logic [511:0] code_row(input logic [4:0] row);
    logic [511:0] s;
    case (row)
      5'd1:  s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSS**VVVVAAAADDEEGGGG";
      5'd2:  s = "FFLLSSSSYY**CCWWTTTTPPPPHHQQRRRRIIMMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd3:  s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd4:  s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSSSVVVVAAAADDEEGGGG";
      5'd5:  s = "FFLLSSSSYYQQCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd8:  s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNNKSSSSVVVVAAAADDEEGGGG";
      5'd9:  s = "FFLLSSSSYY**CCCWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd11: s = "FFLLSSSSYY**CC*WLLLSPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd12: s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSGGVVVVAAAADDEEGGGG";
      5'd13: s = "FFLLSSSSYYY*CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNNKSSSSVVVVAAAADDEEGGGG";
      5'd14: s = "FFLLSSSSYY*QCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd15: s = "FFLLSSSSYY*LCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd20: s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNNKSSSSVVVVAAAADDEEGGGG";
      5'd21: s = "FFLLSS*SYY*LCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd22: s = "FF*LSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      default: s = "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
    endcase
    return s;
  endfunction

  // Mask bit (A,C,G,T) to position in TCAG order
  function automatic logic [1:0] tcag_of_bit(input logic [1:0] b);
    logic [1:0] r;
    case (b)
      2'd0: r = 2'd2;
      2'd1: r = 2'd1;
      2'd2: r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] merge_aa(input logic [4:0] acc, input logic [4:0] x);
    logic [4:0] r;
    if (acc == AaNone) r = x;
    else if (acc == x) r = acc;
    else if ((acc == AaB || acc == AaD || acc == AaN) &&
             (x == AaB || x == AaD || x == AaN)) r = AaB;
    else if ((acc == AaZ || acc == AaE || acc == AaQ) &&
             (x == AaZ || x == AaE || x == AaQ)) r = AaZ;
    else r = AaX;
    return r;
  endfunction

endpackage

FILE: rtl/act_framer.sv
`timescale 1ns / 1ps
module act_framer import act_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  act_in_t    item_i,
  output logic       done_o,
  output logic [3:0] m1_o,
  output logic [3:0] m2_o,
  output logic [3:0] m3_o
);
  logic [3:0] held0_q, held1_q;
  logic [1:0] phase_q, phase_d, skip_q, skip_d, ph, sk;
  logic [3:0] b;

  // Complement on the reverse strand: swap A/T and C/G bits
  assign b = item_i.reverse_strand ?
             {item_i.base[0], item_i.base[1], item_i.base[2], item_i.base[3]} : item_i.base;

  always_comb begin
    ph = item_i.first_base ? 2'd0 : phase_q;
    sk = item_i.first_base ? ((item_i.skip_bases == 2'd3) ? 2'd2 : item_i.skip_bases) : skip_q;
    done_o  = 1'b0;
    phase_d = ph;
    skip_d  = sk;
    if (sk != 2'd0) begin
      skip_d = sk - 2'd1;
    end else if (ph >= 2'd2) begin
      done_o  = 1'b1;
      phase_d = 2'd0;
    end else begin
      phase_d = ph + 2'd1;
    end
    if (item_i.last_base) begin
      phase_d = 2'd0;
      skip_d  = 2'd0;
    end
  end

  assign m1_o = held0_q;
  assign m2_o = held1_q;
  assign m3_o = b;

  // Advance frame state and hold bases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      skip_q  <= 2'd0;
      held0_q <= 4'd0;
      held1_q <= 4'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      if (sk == 2'd0 && ph < 2'd2) begin
        if (ph[0]) held1_q <= b;
        else       held0_q <= b;
      end
    end
  end
endmodule

FILE: rtl/act_translate.sv
`timescale 1ns / 1ps
module act_translate import act_pkg::*; (
  input  logic [4:0] code_i,
  input  logic [3:0] m1_i,
  input  logic [3:0] m2_i,
  input  logic [3:0] m3_i,
  output logic [4:0] aa_o
);
  logic [511:0] row;
  logic [4:0]   rsel, single;
  logic [5:0]   idx;
  logic [27:0]  seen;

  // Unused code numbers fall back to the standard code
  always_comb begin
    rsel = 5'd0;
    if (code_i >= 5'd1 && 32'(code_i) <= CodeCount && code_i <= 5'd23 &&
        code_i != 5'd7 && code_i != 5'd8 &&
        !(code_i >= 5'd17 && code_i <= 5'd20))
      rsel = code_i - 5'd1;
    row = code_row(rsel);
  end

  // Mark every residue reached by the 64 concrete codons the masks allow
  always_comb begin
    seen = '0;
    idx  = 6'd0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          idx = {tcag_of_bit(2'(i)), tcag_of_bit(2'(j)), tcag_of_bit(2'(k))};
          if (m1_i[i] && m2_i[j] && m3_i[k]) begin
            seen[aa_of_char(row[(7'd63 - 7'(idx)) * 8 +: 8])] = 1'b1;
          end
        end
      end
    end
  end

  // Reduce the set: one residue stands, D/N mixes give B, E/Q mixes give Z, else X
  always_comb begin
    single = AaNone;
    for (int n = 0; n < 28; n++) begin
      if (seen[n]) single = single | 5'(n);
    end
    if (seen == '0) aa_o = AaX;
    else if ((seen & (seen - 28'd1)) == '0) aa_o = single;
    else if ((seen & ~AaSetBdn) == '0) aa_o = AaB;
    else if ((seen & ~AaSetZeq) == '0) aa_o = AaZ;
    else aa_o = AaX;
  end
endmodule

FILE: rtl/ambiguous_codon_translator.sv
`timescale 1ns / 1ps
// Result: registered on out_valid_o in the cycle after its item is accepted.
// Throughput: one item per cycle unless out_ready_i stalls the output register.
// Reset: frame state and held bases clear, both code registers load 1,
// no result is pending.
module ambiguous_codon_translator import act_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  act_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output act_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [4:0] cfg_data_i
);
  logic [4:0] query_q, db_q, aa;
  logic [3:0] m1, m2, m3;
  logic       step, done;
  act_out_t   out_q;
  logic       out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  act_framer u_framer (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_data_i),
    .done_o(done), .m1_o(m1), .m2_o(m2), .m3_o(m3)
  );

  act_translate u_translate (
    .code_i(in_data_i.use_db_table ? db_q : query_q),
    .m1_i(m1), .m2_i(m2), .m3_i(m3), .aa_o(aa)
  );

  // Write code registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= 5'd1;
      db_q    <= 5'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegQueryCode) query_q <= cfg_data_i;
      else                             db_q    <= cfg_data_i;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= step && (done || in_data_i.last_base);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.amino_acid     <= done ? aa : AaNone;
      out_q.end_of_protein <= in_data_i.last_base;
      out_q.no_residue     <= !done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

FILE: sim/ambiguous_codon_translator_tb.sv
`timescale 1ns / 1ps
module ambiguous_codon_translator_tb;
  import act_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 8;
  localparam int InBits = $bits(act_in_t);

  // Genetic code rows in TCAG order, row 0 is the standard code
  localparam string CodeStd = "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
  localparam string AaSyms = "-ABCDEFGHIKLMNPQRSTVWXYZU*OJ";

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  act_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  act_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [4:0] cfg_data;

  ambiguous_codon_translator u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Directed rows; check_aa set where the result is obvious at a glance
  typedef struct {
    act_in_t    it;
    bit         check_aa;
    logic [4:0] aa;
  } row_t;

  row_t rows[$];
  row_t dir_q[$];

  // Translator state mirrored for prediction
  logic [4:0] tr_query_code;
  logic [4:0] tr_db_code;
  logic [3:0] tr_held [2];
  logic [1:0] tr_phase;
  logic [1:0] tr_skip;

  act_out_t   residue_q[$];
  int         errors;
  int         mismatches;
  int         n_items;
  int         n_results;
  int         n_ends;
  int         idle_cycles;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         recv_hold;
  bit         timed_out;

  function automatic string code_table(input logic [4:0] num);
    string s;
    s = CodeStd;
    case (num)
      5'd2:  s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSS**VVVVAAAADDEEGGGG";
      5'd3:  s = "FFLLSSSSYY**CCWWTTTTPPPPHHQQRRRRIIMMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd4:  s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd5:  s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSSSVVVVAAAADDEEGGGG";
      5'd6:  s = "FFLLSSSSYYQQCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd9:  s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNNKSSSSVVVVAAAADDEEGGGG";
      5'd10: s = "FFLLSSSSYY**CCCWLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd12: s = "FFLLSSSSYY**CC*WLLLSPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd13: s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNKKSSGGVVVVAAAADDEEGGGG";
      5'd14: s = "FFLLSSSSYYY*CCWWLLLLPPPPHHQQRRRRIIIMTTTTNNNKSSSSVVVVAAAADDEEGGGG";
      5'd15: s = "FFLLSSSSYY*QCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd16: s = "FFLLSSSSYY*LCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd21: s = "FFLLSSSSYY**CCWWLLLLPPPPHHQQRRRRIIMMTTTTNNNKSSSSVVVVAAAADDEEGGGG";
      5'd22: s = "FFLLSS*SYY*LCC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      5'd23: s = "FF*LSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";
      default: s = CodeStd;
    endcase
    return s;
  endfunction

  function automatic int tcag_pos(input int bit_idx);
    case (bit_idx)
      0: return 2;
      1: return 1;
      2: return 3;
      default: return 0;
    endcase
  endfunction

  function automatic logic [4:0] symbol_index(input byte c);
    for (int i = 0; i < 28; i++) if (AaSyms[i] == c) return 5'(i);
    return AaX;
  endfunction

  // Merge every concrete codon the masks allow into one residue
  function automatic logic [4:0] merged_residue(input logic [4:0] num, input logic [3:0] m1,
                                                input logic [3:0] m2, input logic [3:0] m3);
    string tbl;
    byte   acc;
    byte   x;
    tbl = code_table(num);
    acc = "-";
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        for (int k = 0; k < 4; k++) begin
          if (m1[i] && m2[j] && m3[k]) begin
            x = tbl[tcag_pos(i) * 16 + tcag_pos(j) * 4 + tcag_pos(k)];
            if (acc == "-" || acc == x) acc = x;
            else if ((acc == "B" || acc == "D" || acc == "N") &&
                     (x == "B" || x == "D" || x == "N")) acc = "B";
            else if ((acc == "Z" || acc == "E" || acc == "Q") &&
                     (x == "Z" || x == "E" || x == "Q")) acc = "Z";
            else acc = "X";
          end
        end
    if (acc == "-") acc = "X";
    return symbol_index(acc);
  endfunction

  // Advance the mirrored frame by one base; return 1 when a result is due
  function automatic bit translate_base(input act_in_t it, output act_out_t res);
    logic [3:0] b;
    bit         have;
    logic [4:0] aa;
    b = it.base;
    have = 1'b0;
    aa = AaNone;
    if (it.reverse_strand) b = {b[0], b[1], b[2], b[3]};
    if (it.first_base) begin
      tr_phase = 2'd0;
      tr_skip = (it.skip_bases > 2'd2) ? 2'd2 : it.skip_bases;
    end
    if (tr_skip > 0) begin
      tr_skip--;
    end else if (tr_phase >= 2) begin
      aa = merged_residue(it.use_db_table ? tr_db_code : tr_query_code, tr_held[0],
                          tr_held[1], b);
      have = 1'b1;
      tr_phase = 2'd0;
    end else begin
      tr_held[tr_phase[0]] = b;
      tr_phase++;
    end
    res = '0;
    if (it.last_base) begin
      tr_phase = 2'd0;
      tr_skip = 2'd0;
      res.amino_acid = have ? aa : AaNone;
      res.end_of_protein = 1'b1;
      res.no_residue = !have;
      return 1'b1;
    end
    res.amino_acid = aa;
    return have;
  endfunction

  // Predict on every accepted item; hold directed rows to their typed result
  always @(posedge clk) begin
    act_out_t r;
    row_t     d;
    bit       have;
    if (rst_n && in_valid && in_ready) begin
      n_items++;
      have = translate_base(in_data, r);
      if (dir_q.size() != 0) begin
        d = dir_q.pop_front();
        if (d.check_aa && have && r.amino_acid !== d.aa) begin
          errors++;
          if (mismatches++ < 10)
            $display("directed row %0d: predictor %0d, table %0d", n_items - 1,
                     r.amino_acid, d.aa);
        end
      end
      if (have) residue_q.push_back(r);
    end
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk) begin
    act_out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_data.end_of_protein) n_ends++;
      if (residue_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %p", out_data);
      end else begin
        want = residue_q.pop_front();
        if (out_data.amino_acid !== want.amino_acid ||
            out_data.end_of_protein !== want.end_of_protein ||
            out_data.no_residue !== want.no_residue) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) timed_out = 1'b1;
  end

  // Offer one item; valid drops only on idle cycles or when draining
  task automatic send_base(input act_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write both code registers back to back
  task automatic write_codes(input logic [4:0] query_value, input logic [4:0] db_value);
    cfg_valid <= 1'b1;
    cfg_index <= RegQueryCode;
    cfg_data <= query_value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tr_query_code = query_value;
    cfg_index <= RegDbCode;
    cfg_data <= db_value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tr_db_code = db_value;
    cfg_valid <= 1'b0;
  endtask

  function automatic act_in_t make_base(input logic [3:0] b, input bit first,
                                        input logic [1:0] skip, input bit rev,
                                        input bit db, input bit last);
    act_in_t it;
    it.base = b;
    it.first_base = first;
    it.skip_bases = skip;
    it.reverse_strand = rev;
    it.use_db_table = db;
    it.last_base = last;
    return it;
  endfunction

  // Well-formed sequence of random length and content, frame and strand
  task automatic send_sequence(input int len);
    bit         rev;
    bit         db;
    logic [1:0] skip;
    logic [3:0] b;
    rev = 1'($urandom_range(1));
    db = 1'($urandom_range(1));
    skip = 2'($urandom_range(3));
    for (int i = 0; i < len; i++) begin
      // mostly concrete bases, some ambiguity codes
      if ($urandom_range(3) == 0) b = 4'($urandom_range(15));
      else b = 4'(4'b1 << $urandom_range(3));
      send_base(make_base(b, i == 0, skip, rev, ($urandom_range(9) == 0) ? !db : db,
                          i == len - 1));
    end
  endtask

  task automatic random_phase(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        // noise item with every field random
        send_base(act_in_t'(InBits'($urandom)));
        sent++;
      end else begin
        len = $urandom_range(1, 20);
        send_sequence(len);
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = RegQueryCode;
    cfg_data = 5'd0;
    errors = 0;
    mismatches = 0;
    n_items = 0;
    n_results = 0;
    n_ends = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    timed_out = 1'b0;
    tr_query_code = 5'd1;
    tr_db_code = 5'd1;
    tr_held[0] = '0;
    tr_held[1] = '0;
    tr_phase = '0;
    tr_skip = '0;

    fork
      begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ATG after reset -> M; empty mask -> X; all-N codon -> X
        rows.push_back('{make_base(4'h1, 1, 0, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h8, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h4, 0, 0, 0, 0, 0), 1, 5'd12});
        rows.push_back('{make_base(4'h0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h1, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h1, 0, 0, 0, 0, 0), 1, AaX});
        rows.push_back('{make_base(4'hf, 0, 0, 0, 1, 0), 0, 0});
        rows.push_back('{make_base(4'hf, 0, 0, 0, 1, 0), 0, 0});
        rows.push_back('{make_base(4'hf, 0, 0, 0, 1, 0), 1, AaX});
        // GAY/AAY -> B (mask A|G first), CAR/GAR -> Z
        rows.push_back('{make_base(4'h5, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h1, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'ha, 0, 0, 0, 0, 0), 1, AaB});
        rows.push_back('{make_base(4'h6, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h1, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h5, 0, 0, 0, 0, 0), 1, AaZ});
        // frame out of range acts as two, reverse strand, end marker alone
        rows.push_back('{make_base(4'h3, 1, 3, 1, 0, 0), 0, 0});
        rows.push_back('{make_base(4'hc, 0, 3, 1, 1, 0), 0, 0});
        rows.push_back('{make_base(4'h8, 0, 3, 1, 1, 1), 1, AaNone});
        // codon completed on the last base, then bases without a start
        rows.push_back('{make_base(4'h2, 1, 1, 0, 1, 0), 0, 0});
        rows.push_back('{make_base(4'h8, 0, 0, 0, 1, 0), 0, 0});
        rows.push_back('{make_base(4'h2, 0, 0, 0, 1, 0), 0, 0});
        rows.push_back('{make_base(4'h4, 0, 0, 0, 1, 1), 0, 0});
        rows.push_back('{make_base(4'h8, 0, 2, 1, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h8, 0, 2, 0, 0, 0), 0, 0});
        rows.push_back('{make_base(4'h4, 0, 2, 0, 0, 1), 1, 5'd12});
        dir_q = rows;
        foreach (rows[i]) begin
          send_base(rows[i].it);
        end
        wait_drained();

        // Unused and extreme code numbers, then random settings between phases
        write_codes(5'd0, 5'd31);
        send_idle_pct = 26;
        recv_idle_pct = 50;
        random_phase(300);
        wait_drained();

        write_codes(5'd23, 5'd2);
        random_phase(250);

        // Hold the output a long while so the input stalls
        recv_hold = 1'b1;
        fork
          begin
            repeat (60) @(posedge clk);
            recv_hold = 1'b0;
          end
          random_phase(20);
        join
        wait_drained();

        write_codes(5'($urandom_range(1, 23)), 5'($urandom_range(24, 31)));
        send_idle_pct = 50;
        recv_idle_pct = 26;
        random_phase(500);
        wait_drained();

        write_codes(5'($urandom_range(1, 23)), 5'($urandom_range(1, 23)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(550);
        wait_drained();
      end
      begin
        wait (timed_out);
      end
    join_any

    if (timed_out) begin
      $display("FAIL ambiguous_codon_translator");
    end else begin
      $display("Sent %0d bases over several code settings; %0d results, %0d sequence ends.",
               n_items, n_results, n_ends);
      if (errors == 0 && residue_q.size() == 0) $display("PASS ambiguous_codon_translator");
      else $display("FAIL ambiguous_codon_translator");
    end
    $finish;
  end

endmodule
